>>> src/cbm_pkg.sv
// Shared types and constants of the cartridge bank mapper.
`default_nettype none

package cbm_pkg;

    // Request kinds
    typedef enum logic [2:0] {
        ACT_TICK  = 3'd0,
        ACT_WRITE = 3'd1,
        ACT_PRG   = 3'd2,
        ACT_CHR   = 3'd3,
        ACT_NT    = 3'd4
    } t_action;

    // One request as held in the input register
    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] address;
        logic [7:0]  write_data;
    } t_item;

    // Register write decode
    localparam logic [15:0] DECODE_MASK  = 16'hf007;
    localparam logic [3:0]  GRP_PRG0     = 4'h8;
    localparam logic [3:0]  GRP_PRG1     = 4'ha;
    localparam logic [3:0]  GRP_CHR      = 4'hb;
    localparam logic [3:0]  GRP_PRG2     = 4'hc;
    localparam logic [15:0] REG_MIRROR   = 16'h9001;
    localparam logic [15:0] REG_IRQ_EN   = 16'h9003;
    localparam logic [15:0] REG_IRQ_LOAD = 16'h9004;
    localparam logic [15:0] REG_RELOAD_H = 16'h9005;
    localparam logic [15:0] REG_RELOAD_L = 16'h9006;

    // Program windows, by address bits 15..13
    localparam logic [2:0] WIN_PRG0  = 3'b100;
    localparam logic [2:0] WIN_PRG1  = 3'b101;
    localparam logic [2:0] WIN_PRG2  = 3'b110;
    localparam logic [2:0] WIN_FIXED = 3'b111;

    localparam logic [7:0] PRG_FIXED_BANK = 8'hff;
    localparam logic [7:0] PRG0_RESET     = 8'h00;
    localparam logic [7:0] PRG1_RESET     = 8'h01;
    localparam logic [7:0] PRG2_RESET     = 8'hfe;

    localparam int MAP_W = 21;

endpackage

`default_nettype wire

>>> src/cartridge_bank_mapper_with_irq_timer.sv
// Top level of the cartridge bank mapper with its CPU-cycle IRQ timer.
//
// Each request is a CPU tick, a register write, or a program, pattern or
// nametable address to translate, and every request yields exactly one
// result: the translated address (zero for ticks and writes) and the IRQ
// line level after the request. The block is a two-register pipeline: a
// request is caught in the input register, then one pass of decode and
// translation logic updates the mapper state and loads the result register
// in the same edge. Sustained rate is one request per cycle while results
// are taken. The mapper state is updated as the request moves into the
// result register, so the next request already sees it. A stalled result
// holds the result register; the input register holds its request, or
// takes one more request if it was empty.
`default_nettype none

module cartridge_bank_mapper_with_irq_timer
    import cbm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // request channel
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [2:0]       i_action,
    input  wire logic [15:0]      i_address,
    input  wire logic [7:0]       i_write_data,
    // result channel
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [MAP_W-1:0]      o_mapped_address,
    output logic                  o_irq_asserted
);

    t_item             item;
    logic              item_valid;
    logic              go;
    logic [MAP_W-1:0]  core_mapped;
    logic              core_irq;

    logic              r_out_valid;
    logic [MAP_W-1:0]  r_mapped;
    logic              r_irq;

    // Advance the held request when the result register is free or draining
    assign go = item_valid && (!r_out_valid || i_out_ready);

    cbm_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_action     (i_action),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .o_valid      (item_valid),
        .i_take       (go),
        .o_item       (item)
    );

    cbm_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (go),
        .i_item   (item),
        .o_mapped (core_mapped),
        .o_irq    (core_irq)
    );

    // Result register: load on advance, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= go || (r_out_valid && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_mapped <= core_mapped;
            r_irq    <= core_irq;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_mapped_address = r_mapped;
    assign o_irq_asserted   = r_irq;

endmodule

`default_nettype wire

>>> src/cbm_in_reg.sv
// Input register stage that holds one request until the core takes it.
`default_nettype none

module cbm_in_reg
    import cbm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_action,
    input  wire logic [15:0] i_address,
    input  wire logic [7:0]  i_write_data,
    output logic             o_valid,
    input  wire logic        i_take,
    output t_item            o_item
);

    logic  r_valid;
    t_item r_item;

    // Free when empty or when the held request leaves this cycle
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_valid && o_ready) || (r_valid && !i_take);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item.action     <= i_action;
            r_item.address    <= i_address;
            r_item.write_data <= i_write_data;
        end
    end

endmodule

`default_nettype wire

>>> src/cbm_core.sv
// Mapper state, register write decode, IRQ counter and address translation.
`default_nettype none

module cbm_core
    import cbm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_go,
    input  wire t_item            i_item,
    output logic [MAP_W-1:0]      o_mapped,
    output logic                  o_irq
);

    logic [7:0]  r_prg [3];
    logic [7:0]  r_chr [8];
    logic        r_mirror_h;
    logic [15:0] r_count;
    logic [15:0] r_reload;
    logic        r_irq_en;
    logic        r_irq_line;

    logic [7:0]  n_prg [3];
    logic [7:0]  n_chr [8];
    logic        n_mirror_h;
    logic [15:0] n_count;
    logic [15:0] n_reload;
    logic        n_irq_en;
    logic        n_irq_line;

    logic [15:0] dec;
    logic [15:0] a;
    logic [7:0]  d;
    logic [15:0] count_dec;

    assign a         = i_item.address;
    assign d         = i_item.write_data;
    assign dec       = a & DECODE_MASK;
    assign count_dec = r_count - 16'd1;

    always_comb begin
        n_prg      = r_prg;
        n_chr      = r_chr;
        n_mirror_h = r_mirror_h;
        n_count    = r_count;
        n_reload   = r_reload;
        n_irq_en   = r_irq_en;
        n_irq_line = r_irq_line;
        o_mapped   = '0;

        unique case (i_item.action)
            ACT_TICK: begin
                if (r_irq_en && (r_count != 16'd0)) begin
                    n_count = count_dec;
                    if (count_dec == 16'd0) begin
                        n_irq_line = 1'b1;
                    end
                end
            end
            ACT_WRITE: begin
                unique case (dec[15:12])
                    GRP_PRG0: n_prg[0] = d;
                    GRP_PRG1: n_prg[1] = d;
                    GRP_CHR:  n_chr[dec[2:0]] = d;
                    GRP_PRG2: n_prg[2] = d;
                    default: begin
                        unique case (dec)
                            REG_MIRROR: n_mirror_h = d[7];
                            REG_IRQ_EN: begin
                                n_irq_en   = d[7];
                                n_irq_line = 1'b0;
                            end
                            REG_IRQ_LOAD: begin
                                n_count    = r_reload;
                                n_irq_line = 1'b0;
                            end
                            REG_RELOAD_H: n_reload[15:8] = d;
                            REG_RELOAD_L: n_reload[7:0]  = d;
                            default: ;
                        endcase
                    end
                endcase
            end
            ACT_PRG: begin
                unique case (a[15:13])
                    WIN_PRG0:  o_mapped = {r_prg[0], a[12:0]};
                    WIN_PRG1:  o_mapped = {r_prg[1], a[12:0]};
                    WIN_PRG2:  o_mapped = {r_prg[2], a[12:0]};
                    WIN_FIXED: o_mapped = {PRG_FIXED_BANK, a[12:0]};
                    default:   o_mapped = '0;
                endcase
            end
            ACT_CHR: begin
                o_mapped = {3'b000, r_chr[a[12:10]], a[9:0]};
            end
            ACT_NT: begin
                // Horizontal mirroring pages on bit 11, vertical on bit 10
                o_mapped = {10'd0, (r_mirror_h ? a[11] : a[10]), a[9:0]};
            end
            default: ;
        endcase
    end

    assign o_irq = n_irq_line;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg[0]   <= PRG0_RESET;
            r_prg[1]   <= PRG1_RESET;
            r_prg[2]   <= PRG2_RESET;
            for (int i = 0; i < 8; i++) begin
                r_chr[i] <= 8'h00;
            end
            r_mirror_h <= 1'b0;
            r_count    <= 16'd0;
            r_reload   <= 16'd0;
            r_irq_en   <= 1'b0;
            r_irq_line <= 1'b0;
        end else if (i_go) begin
            r_prg      <= n_prg;
            r_chr      <= n_chr;
            r_mirror_h <= n_mirror_h;
            r_count    <= n_count;
            r_reload   <= n_reload;
            r_irq_en   <= n_irq_en;
            r_irq_line <= n_irq_line;
        end
    end

endmodule

`default_nettype wire

>>> src/cbm_checker.sv
// Port-level assertions for the mapper top level and the bind that attaches them.
`default_nettype none

module cbm_checker
    import cbm_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             o_in_ready,
    input wire logic [2:0]       i_action,
    input wire logic [15:0]      i_address,
    input wire logic [7:0]       i_write_data,
    input wire logic             o_out_valid,
    input wire logic             i_out_ready,
    input wire logic [MAP_W-1:0] o_mapped_address,
    input wire logic             o_irq_asserted
);

    // No result survives reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // An empty result register never blocks requests
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("request blocked with empty result register");

    // A request accepted into an empty pipe passes through the input register into the result register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !o_out_valid && $past(o_in_ready)
         && !$past(i_in_valid)) |=> ##1 o_out_valid)
        else $error("request did not reach the result register");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_mapped_address) && $stable(o_irq_asserted)))
        else $error("stalled result changed");

endmodule

bind cartridge_bank_mapper_with_irq_timer cbm_checker u_cbm_checker (.*);

`default_nettype wire
